>>> rtl/core/websocket_frame_receiver_defines.svh
// assertion macros shared by the frame receiver files
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// checked on aclk, switched off while aresetn is low
`define WSFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
    else $error("wsfr assertion failed");

// checked on aclk at every edge, reset included
`define WSFR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
    else $error("wsfr assertion failed");

`else

`define WSFR_ASSERT(lbl, prop)
`define WSFR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/core/wsfr_pkg.sv
package wsfr_pkg;

    // length handling
    localparam int LENGTH_BITS  = 63;
    localparam int LEN_ACC_BITS = 63;
    localparam logic [LEN_ACC_BITS-1:0] LEN_MAX =
        {LEN_ACC_BITS{1'b1}} >> (LEN_ACC_BITS - LENGTH_BITS);

    // queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // 7-bit length codes
    localparam logic [6:0] LEN7_CONTROL_MAX = 7'd125;
    localparam logic [6:0] LEN7_EXT16       = 7'd126;
    localparam logic [6:0] LEN7_EXT64       = 7'd127;

    // header byte masks
    localparam logic [7:0] HDR_RSV_MASK = 8'h70;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_RESERVED     = 3'd1;
    localparam logic [2:0] ERR_CTRL_LONG    = 3'd2;
    localparam logic [2:0] ERR_MASK         = 3'd3;
    localparam logic [2:0] ERR_OPCODE       = 3'd4;
    localparam logic [2:0] ERR_CTRL_FRAG    = 3'd5;
    localparam logic [2:0] ERR_ORPHAN_CONT  = 3'd6;
    localparam logic [2:0] ERR_INTERLEAVED  = 3'd7;

    // one command from parser to output stage
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic [3:0] frame_opcode;
        logic [3:0] message_opcode;
        logic       final_fragment;
        logic       last_of_frame;
        logic       message_complete;
        logic [2:0] error_code;
        logic       close_seen;
    } cmd_t;

    // one finished result
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic [3:0] message_opcode;
        logic       final_fragment;
        logic       last_of_frame;
        logic       message_complete;
        logic [2:0] error_code;
        logic       close_seen;
    } result_t;

    function automatic logic is_control(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

>>> rtl/core/wsfr_front.sv
`include "websocket_frame_receiver_defines.svh"

module wsfr_front
    import wsfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       server_side,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    typedef enum logic [5:0] {
        PH_HEAD0   = 6'b000001,
        PH_HEAD1   = 6'b000010,
        PH_LEN16   = 6'b000100,
        PH_LEN64   = 6'b001000,
        PH_MASK    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [7:0]                first_byte_reg, first_byte_next;
    logic                      fin_reg, fin_next;
    logic [3:0]                code_reg, code_next;
    logic                      masked_reg, masked_next;
    logic [LEN_ACC_BITS-1:0]   acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]    remaining_reg, remaining_next;
    logic                      len_zero_reg, len_zero_next;
    logic [2:0]                cnt_reg, cnt_next;
    logic [31:0]               key_reg, key_next;
    logic [1:0]                key_idx_reg, key_idx_next;
    logic                      msg_open_reg, msg_open_next;
    logic [3:0]                open_code_reg, open_code_next;
    logic                      close_reg, close_next;
    logic                      halted_reg, halted_next;

    logic                      accept;
    logic                      hdr_fin;
    logic [3:0]                hdr_code;
    logic                      hdr_masked;
    logic [6:0]                len7;
    logic [2:0]                hdr_err;
    logic [LEN_ACC_BITS-1:0]   acc_shift;
    logic [LENGTH_BITS-1:0]    len16_value;
    logic [LENGTH_BITS-1:0]    len64_value;
    logic [7:0]                key_byte;
    logic                      cur_fin;
    logic [3:0]                cur_code;
    logic                      cur_masked;
    logic                      frame_ends_msg;
    logic                      do_after_len;
    logic [LENGTH_BITS-1:0]    len_value;
    logic                      do_empty;
    logic                      do_close;
    logic                      last_byte;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign hdr_fin    = first_byte_reg[7];
    assign hdr_code   = first_byte_reg[3:0];
    assign hdr_masked = s_rx_byte[7];
    assign len7       = s_rx_byte[6:0];

    // header checks, lowest code wins
    always_comb begin
        if ((first_byte_reg & HDR_RSV_MASK) != 8'h00) begin
            hdr_err = ERR_RESERVED;
        end else if (hdr_code[3] && (len7 > LEN7_CONTROL_MAX)) begin
            hdr_err = ERR_CTRL_LONG;
        end else if (server_side != hdr_masked) begin
            hdr_err = ERR_MASK;
        end else if (!((hdr_code <= OP_BINARY) || is_control(hdr_code))) begin
            hdr_err = ERR_OPCODE;
        end else if (!hdr_fin && is_control(hdr_code)) begin
            hdr_err = ERR_CTRL_FRAG;
        end else if (!msg_open_reg && (hdr_code == OP_CONT)) begin
            hdr_err = ERR_ORPHAN_CONT;
        end else if (msg_open_reg && ((hdr_code == OP_TEXT) || (hdr_code == OP_BINARY))) begin
            hdr_err = ERR_INTERLEAVED;
        end else begin
            hdr_err = ERR_NONE;
        end
    end

    assign acc_shift   = {acc_reg[LEN_ACC_BITS-9:0], s_rx_byte};
    assign len16_value = LENGTH_BITS'(acc_shift[15:0]);
    assign len64_value = (acc_shift > LEN_MAX) ? LENGTH_BITS'(LEN_MAX)
                                               : LENGTH_BITS'(acc_shift);

    always_comb begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // header fields take effect on the second header byte
    assign cur_fin        = (phase_reg == PH_HEAD1) ? hdr_fin : fin_reg;
    assign cur_code       = (phase_reg == PH_HEAD1) ? hdr_code : code_reg;
    assign cur_masked     = (phase_reg == PH_HEAD1) ? hdr_masked : masked_reg;
    assign frame_ends_msg = cur_fin && (cur_code <= OP_BINARY);
    assign last_byte      = (remaining_reg == LENGTH_BITS'(1));

    always_comb begin
        phase_next      = phase_reg;
        first_byte_next = first_byte_reg;
        fin_next        = fin_reg;
        code_next       = code_reg;
        masked_next     = masked_reg;
        acc_next        = acc_reg;
        remaining_next  = remaining_reg;
        len_zero_next   = len_zero_reg;
        cnt_next        = cnt_reg;
        key_next        = key_reg;
        key_idx_next    = key_idx_reg;
        msg_open_next   = msg_open_reg;
        open_code_next  = open_code_reg;
        close_next      = close_reg;
        halted_next     = halted_reg;
        do_after_len    = 1'b0;
        len_value       = '0;
        do_empty        = 1'b0;
        do_close        = 1'b0;
        push            = 1'b0;

        push_cmd.kind             = KIND_PAYLOAD;
        push_cmd.raw_byte         = s_rx_byte;
        push_cmd.key_byte         = key_byte;
        push_cmd.frame_opcode     = cur_code;
        push_cmd.message_opcode   = msg_open_reg ? open_code_reg : cur_code;
        push_cmd.final_fragment   = cur_fin;
        push_cmd.last_of_frame    = 1'b0;
        push_cmd.message_complete = 1'b0;
        push_cmd.error_code       = ERR_NONE;
        push_cmd.close_seen       = close_reg;

        if (accept && !halted_reg) begin
            case (phase_reg)
                PH_HEAD0: begin
                    first_byte_next = s_rx_byte;
                    phase_next      = PH_HEAD1;
                end
                PH_HEAD1: begin
                    fin_next    = hdr_fin;
                    code_next   = hdr_code;
                    masked_next = hdr_masked;
                    if ((hdr_err == ERR_CTRL_LONG) && (hdr_code == OP_CLOSE)) begin
                        close_next = 1'b1;
                    end
                    if (hdr_err != ERR_NONE) begin
                        halted_next         = 1'b1;
                        push                = 1'b1;
                        push_cmd.kind       = KIND_ERROR;
                        push_cmd.error_code = hdr_err;
                        push_cmd.close_seen = close_next;
                    end else begin
                        key_next     = '0;
                        key_idx_next = '0;
                        acc_next     = '0;
                        cnt_next     = '0;
                        if (len7 == LEN7_EXT16) begin
                            phase_next = PH_LEN16;
                        end else if (len7 == LEN7_EXT64) begin
                            phase_next = PH_LEN64;
                        end else begin
                            do_after_len = 1'b1;
                            len_value    = LENGTH_BITS'(len7);
                        end
                    end
                end
                PH_LEN16: begin
                    acc_next = acc_shift;
                    if (cnt_reg >= 3'd1) begin
                        do_after_len = 1'b1;
                        len_value    = len16_value;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_LEN64: begin
                    acc_next = acc_shift;
                    if (cnt_reg >= 3'd7) begin
                        do_after_len = 1'b1;
                        len_value    = len64_value;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_MASK: begin
                    key_next = {key_reg[23:0], s_rx_byte};
                    if (cnt_reg >= 3'd3) begin
                        cnt_next   = '0;
                        phase_next = PH_PAYLOAD;
                        do_empty   = len_zero_reg;
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    push                      = 1'b1;
                    push_cmd.last_of_frame    = last_byte;
                    push_cmd.message_complete = last_byte && frame_ends_msg;
                    key_idx_next              = key_idx_reg + 2'd1;
                    remaining_next            = remaining_reg - LENGTH_BITS'(1);
                    do_close                  = last_byte;
                end
                default: begin
                    phase_next = PH_HEAD0;
                end
            endcase
        end

        if (do_after_len) begin
            cnt_next       = '0;
            remaining_next = len_value;
            len_zero_next  = (len_value == '0);
            if (cur_masked) begin
                phase_next = PH_MASK;
            end else begin
                phase_next = PH_PAYLOAD;
                do_empty   = (len_value == '0);
            end
        end

        if (do_empty) begin
            push                      = 1'b1;
            push_cmd.kind             = KIND_EMPTY;
            push_cmd.last_of_frame    = 1'b1;
            push_cmd.message_complete = frame_ends_msg;
            do_close                  = 1'b1;
        end

        if (do_close) begin
            if (!cur_fin && ((cur_code == OP_TEXT) || (cur_code == OP_BINARY))) begin
                msg_open_next  = 1'b1;
                open_code_next = cur_code;
            end else if (frame_ends_msg) begin
                msg_open_next  = 1'b0;
                open_code_next = OP_CONT;
            end
            phase_next = PH_HEAD0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEAD0;
            first_byte_reg <= '0;
            fin_reg        <= 1'b0;
            code_reg       <= '0;
            masked_reg     <= 1'b0;
            acc_reg        <= '0;
            remaining_reg  <= '0;
            len_zero_reg   <= 1'b1;
            cnt_reg        <= '0;
            key_reg        <= '0;
            key_idx_reg    <= '0;
            msg_open_reg   <= 1'b0;
            open_code_reg  <= '0;
            close_reg      <= 1'b0;
            halted_reg     <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            first_byte_reg <= first_byte_next;
            fin_reg        <= fin_next;
            code_reg       <= code_next;
            masked_reg     <= masked_next;
            acc_reg        <= acc_next;
            remaining_reg  <= remaining_next;
            len_zero_reg   <= len_zero_next;
            cnt_reg        <= cnt_next;
            key_reg        <= key_next;
            key_idx_reg    <= key_idx_next;
            msg_open_reg   <= msg_open_next;
            open_code_reg  <= open_code_next;
            close_reg      <= close_next;
            halted_reg     <= halted_next;
        end
    end

    // once halted, only reset clears it
    `WSFR_ASSERT(a_halt_sticky, halted_reg |=> halted_reg)
    // an error report always halts the parser
    `WSFR_ASSERT(a_error_halts, (push && (push_cmd.kind == KIND_ERROR)) |=> halted_reg)
    // nothing leaves a halted parser
    `WSFR_ASSERT(a_silent_when_halted, halted_reg |-> !push)

endmodule

>>> rtl/core/wsfr_queue.sv
`include "websocket_frame_receiver_defines.svh"

module wsfr_queue
    import wsfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // the parser must never offer a command to a full queue
    `WSFR_ASSERT(a_no_overflow, push |-> !full)
    // fill level stays within the queue
    `WSFR_ASSERT(a_count_bound, count_reg <= QUEUE_CW'(QUEUE_DEPTH))

endmodule

>>> rtl/core/wsfr_back.sv
`include "websocket_frame_receiver_defines.svh"

module wsfr_back
    import wsfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_data_byte,
    output logic [3:0] m_frame_opcode,
    output logic [3:0] m_message_opcode,
    output logic       m_final_fragment,
    output logic       m_last_of_frame,
    output logic       m_message_complete,
    output logic [2:0] m_error_code,
    output logic       m_close_seen
);

    logic    out_valid_reg, out_valid_next;
    result_t result_reg;
    result_t result_next;

    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    // unmask payload bytes, zero data on the other kinds
    always_comb begin
        result_next.out_kind         = q_cmd.kind;
        result_next.data_byte        = (q_cmd.kind == KIND_PAYLOAD)
                                       ? (q_cmd.raw_byte ^ q_cmd.key_byte) : 8'h00;
        result_next.frame_opcode     = q_cmd.frame_opcode;
        result_next.message_opcode   = q_cmd.message_opcode;
        result_next.final_fragment   = q_cmd.final_fragment;
        result_next.last_of_frame    = q_cmd.last_of_frame;
        result_next.message_complete = q_cmd.message_complete;
        result_next.error_code       = q_cmd.error_code;
        result_next.close_seen       = q_cmd.close_seen;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            result_reg <= result_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_out_kind         = result_reg.out_kind;
    assign m_data_byte        = result_reg.data_byte;
    assign m_frame_opcode     = result_reg.frame_opcode;
    assign m_message_opcode   = result_reg.message_opcode;
    assign m_final_fragment   = result_reg.final_fragment;
    assign m_last_of_frame    = result_reg.last_of_frame;
    assign m_message_complete = result_reg.message_complete;
    assign m_error_code       = result_reg.error_code;
    assign m_close_seen       = result_reg.close_seen;

    // only payload results carry a data byte
    `WSFR_ASSERT(a_data_zero,
        (out_valid_reg && (result_reg.out_kind != KIND_PAYLOAD)) |-> (result_reg.data_byte == 8'h00))

endmodule

>>> rtl/core/websocket_frame_receiver.sv
// WebSocket frame receiver: takes the raw byte stream of a connection after the opening
// handshake, one byte per s_ transfer, parses each frame header (FIN, opcode, mask bit,
// 7/16/64-bit big-endian length, 4-byte masking key) and hands out every payload byte
// unmasked on the m_ channel together with its frame opcode, the opcode of the open
// fragmented message, FIN and end-of-frame / end-of-message flags. A frame with no payload
// gives a single "empty frame" result on the byte that ends its header. Header bytes give
// no result. Protocol violations (reserved bits, long or fragmented control frames, mask
// bit wrong for the side, reserved opcodes, continuation/data ordering) are reported once
// as an error result; the receiver then swallows every further byte silently until reset.
// server_side (reset 1) is written through the cfg_ channel, which is always ready, and is
// only looked at on the second header byte. One byte is taken per cycle sustained; a
// result passes from the parser through the two-entry queue into the output register on m_,
// and s_ready drops only when the queue is full because m_ready has been held low.

module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_server_side,

    // received byte stream
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,

    // result stream
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_data_byte,
    output logic [3:0] m_frame_opcode,
    output logic [3:0] m_message_opcode,
    output logic       m_final_fragment,
    output logic       m_last_of_frame,
    output logic       m_message_complete,
    output logic [2:0] m_error_code,
    output logic       m_close_seen
);

    logic server_side_reg;
    logic server_side_next;

    // parser to queue
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // queue to output stage
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    // the side register takes a write in any cycle
    assign cfg_ready        = 1'b1;
    assign server_side_next = (cfg_valid && cfg_ready) ? cfg_server_side : server_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_side_reg <= 1'b1;
        end else begin
            server_side_reg <= server_side_next;
        end
    end

    // front: byte-by-byte header parse, checks and payload tagging
    wsfr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .server_side (server_side_reg),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // short queue so a stalled consumer does not stop the parser at once
    wsfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    // back: unmasking and the registered result transfer
    wsfr_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_cmd              (q_cmd),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_kind         (m_out_kind),
        .m_data_byte        (m_data_byte),
        .m_frame_opcode     (m_frame_opcode),
        .m_message_opcode   (m_message_opcode),
        .m_final_fragment   (m_final_fragment),
        .m_last_of_frame    (m_last_of_frame),
        .m_message_complete (m_message_complete),
        .m_error_code       (m_error_code),
        .m_close_seen       (m_close_seen)
    );

endmodule
